>>> src/substring_search_assert.svh
// Assertion macros shared by the substring search checker.
`ifndef SUBSTRING_SEARCH_ASSERT_SVH
`define SUBSTRING_SEARCH_ASSERT_SVH

// Check a property on every edge outside reset.
`define SS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// Check a property on every edge, reset included.
`define SS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

>>> src/ss_pkg.sv
// Types, constants and helpers shared by the substring search block.
`timescale 1ns / 1ps
`default_nettype none

package ss_pkg;

  localparam int LEN_W     = 5;
  localparam int OFF_W     = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD_CASE  = 2'd3;

  typedef struct packed {
    logic [2*CFG_W-1:0] needle;
    logic [LEN_W-1:0]   needle_length;
    logic               fold_case;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [OFF_W-1:0] match_offset;
    logic             overflow;
  } res_t;

  // Upper-case ASCII letters when folding is on
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && b >= 8'h61 && b <= 8'h7A) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/ss_cfg.sv
// Configuration register file: needle bytes, needle length, case folding.
`timescale 1ns / 1ps
`default_nettype none

module ss_cfg
  import ss_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                      cfg
);

  logic [CFG_W-1:0] needle_lo;
  logic [CFG_W-1:0] needle_hi;
  logic [LEN_W-1:0] needle_len;
  logic             fold;

  // Write one register per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_lo  <= '0;
      needle_hi  <= '0;
      needle_len <= '0;
      fold       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NEEDLE_LO:  needle_lo  <= cfg_wdata;
        CFG_NEEDLE_HI:  needle_hi  <= cfg_wdata;
        CFG_NEEDLE_LEN: needle_len <= cfg_wdata[LEN_W-1:0];
        CFG_FOLD_CASE:  fold       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg.needle        = {needle_hi, needle_lo};
  assign cfg.needle_length = needle_len;
  assign cfg.fold_case     = fold;

endmodule

`default_nettype wire

>>> src/ss_track.sv
// Search state: byte window, byte counter, match compare and result decision.
`timescale 1ns / 1ps
`default_nettype none

module ss_track
  import ss_pkg::*;
#(
  parameter int MAX_NEEDLE   = 16,
  parameter int MAX_HAYSTACK = 65536
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] s1_byte,
  input  wire logic       s1_last,
  input  wire cfg_t       cfg,
  output res_t            res
);

  localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int CNT_W = $clog2(MAX_HAYSTACK + 2);
  localparam logic [CNT_W-1:0] HAY_MAX    = CNT_W'(MAX_HAYSTACK);
  localparam logic [CNT_W-1:0] HAY_OVER   = CNT_W'(MAX_HAYSTACK + 1);
  localparam logic [LEN_W-1:0] NEEDLE_MAX = LEN_W'(MAX_NEEDLE);

  logic [7:0]       window       [MAX_NEEDLE];
  logic [7:0]       window_next  [MAX_NEEDLE];
  logic [7:0]       window_shift [MAX_NEEDLE];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] start_pos;
  logic [CNT_W+OFF_W-1:0] start_ext;
  logic             given;
  logic             given_next;
  logic [LEN_W-1:0] len;
  logic [MAX_NEEDLE-1:0] lane_ok;
  logic             hit;

  // Saturate the needle length to the window depth
  assign len = (cfg.needle_length > NEEDLE_MAX) ? NEEDLE_MAX : cfg.needle_length;

  // Window as it stands once the new byte is shifted in
  always_comb begin
    window_shift[0] = s1_byte;
    for (int k = 1; k < MAX_NEEDLE; k++) begin
      window_shift[k] = window[k-1];
    end
  end

  // Compare each needle byte with its aligned window byte
  for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_lane
    logic [LEN_W-1:0] pos;
    assign pos = len - LEN_W'(i) - LEN_W'(1);
    assign lane_ok[i] = (LEN_W'(i) >= len) ||
        (fold_byte(cfg.needle[8*i +: 8], cfg.fold_case) ==
         fold_byte(window_shift[pos[IDX_W-1:0]], cfg.fold_case));
  end

  assign count_inc = count + CNT_W'(1);
  assign hit       = (count_inc >= CNT_W'(len)) && (&lane_ok);
  assign start_pos = count_inc - CNT_W'(len);
  assign start_ext = {{OFF_W{1'b0}}, start_pos};

  // Decide the result and the next search state for the beat in stage one
  always_comb begin
    res         = '0;
    window_next = window;
    count_next  = count;
    given_next  = given;
    if (step) begin
      if (given) begin
        if (s1_last) begin
          for (int k = 0; k < MAX_NEEDLE; k++) window_next[k] = 8'd0;
          count_next = '0;
          given_next = 1'b0;
        end
      end else if (count >= HAY_MAX) begin
        // Past the bound: stop searching, report overflow at the end
        count_next = HAY_OVER;
        if (s1_last) begin
          res.valid    = 1'b1;
          res.overflow = 1'b1;
          for (int k = 0; k < MAX_NEEDLE; k++) window_next[k] = 8'd0;
          count_next = '0;
          given_next = 1'b0;
        end
      end else begin
        window_next = window_shift;
        count_next  = count_inc;
        if (hit) begin
          res.valid        = 1'b1;
          res.found        = 1'b1;
          res.match_offset = (len == '0) ? '0 : start_ext[OFF_W-1:0];
          given_next       = !s1_last;
          if (s1_last) begin
            for (int k = 0; k < MAX_NEEDLE; k++) window_next[k] = 8'd0;
            count_next = '0;
          end
        end else if (s1_last) begin
          res.valid = 1'b1;
          for (int k = 0; k < MAX_NEEDLE; k++) window_next[k] = 8'd0;
          count_next = '0;
          given_next = 1'b0;
        end
      end
    end
  end

  // Hold the search state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_NEEDLE; k++) window[k] <= 8'd0;
      count <= '0;
      given <= 1'b0;
    end else begin
      window <= window_next;
      count  <= count_next;
      given  <= given_next;
    end
  end

endmodule

`default_nettype wire

>>> src/substring_search.sv
// A result passes through the input register and then the result register.
// Throughput: one haystack byte per cycle unless a held result stalls it; the
// window compare covers every needle position between input and result registers.
// Reset (synchronous, active high) clears the window, counter, stage valids
// and the configuration (empty needle, case folding on).
`timescale 1ns / 1ps
`default_nettype none

module substring_search
  import ss_pkg::*;
#(
  parameter int MAX_NEEDLE   = 16,
  parameter int MAX_HAYSTACK = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      found,
  output logic [OFF_W-1:0]          match_offset,
  output logic                      overflow
);

  cfg_t       cfg;
  res_t       res;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       out_free;
  logic       step;

  ss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ss_track #(
    .MAX_NEEDLE   (MAX_NEEDLE),
    .MAX_HAYSTACK (MAX_HAYSTACK)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .s1_byte (s1_byte),
    .s1_last (s1_last),
    .cfg     (cfg),
    .res     (res)
  );

  // Stage one advances whenever the result register can take a beat
  assign out_free = !out_valid || out_ready;
  assign step     = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      found        <= res.found;
      match_offset <= res.match_offset;
      overflow     <= res.overflow;
    end
  end

endmodule

`default_nettype wire

>>> src/ss_checker.sv
// Port-level checker for the substring search block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "substring_search_assert.svh"

module ss_checker
  import ss_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             found,
  input wire logic [OFF_W-1:0] match_offset,
  input wire logic             overflow
);

  logic             out_stall;
  logic [OFF_W+1:0] res_bits;

  assign out_stall = out_valid && !out_ready;
  assign res_bits  = {found, match_offset, overflow};

  // A match never reports overflow
  `SS_ASSERT(a_found_no_overflow, clk, rst, out_valid |-> !(found && overflow))

  // A miss carries a zero offset
  `SS_ASSERT(a_miss_zero_offset, clk, rst, (out_valid && !found) |-> (match_offset == '0))

  // Input stalls only behind a blocked result
  `SS_ASSERT(a_stall_cause, clk, rst, !in_ready |-> out_stall)

  // A stalled result beat holds
  `SS_ASSERT(a_out_hold, clk, rst, out_stall |=> (out_valid && $stable(res_bits)))

  // Reset empties both stages
  `SS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!out_valid && in_ready))

endmodule

bind substring_search ss_checker u_ss_checker (.*);

`default_nettype wire

>>> sim/tb.sv
// Testbench for the streaming substring search block.
`timescale 1ns / 1ps

module tb;
  import ss_pkg::*;

  localparam int NEEDLE_SLOTS = 16;
  localparam int HAY_LIMIT    = 65536;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_SPAN    = 300;

  typedef logic [7:0] octet_t;

  typedef struct {
    logic             found;
    logic [OFF_W-1:0] offset;
    logic             ovf;
  } search_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           data_byte;
  logic                 last_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 found;
  logic [OFF_W-1:0]     match_offset;
  logic                 overflow;

  // Predictor copy of the registers and the search state
  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [4:0]  pat_len;
  logic        fold_on;
  octet_t      win_bytes [NEEDLE_SLOTS];
  int          bytes_seen;
  bit          hit_reported;

  search_result_t pending_results [$];
  int             sent_bytes;
  int             fault_count;
  int             idle_cycles;
  int             send_idle_pct;
  int             recv_idle_pct;
  bit             hold_go;
  bit             hold_seen;
  int             hold_left;

  substring_search #(
    .MAX_NEEDLE  (NEEDLE_SLOTS),
    .MAX_HAYSTACK(HAY_LIMIT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .match_offset(match_offset),
    .overflow    (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Upper-case ASCII letters when folding is on
  function automatic octet_t caps(input octet_t b);
    if (fold_on && b >= 8'h61 && b <= 8'h7A) return b - 8'h20;
    return b;
  endfunction

  // Pack up to eight characters, first one in the low byte
  function automatic logic [63:0] text_word(input string s);
    logic [63:0] w;
    int i;
    w = '0;
    for (i = 0; i < s.len() && i < 8; i++) w[i*8 +: 8] = s[i];
    return w;
  endfunction

  task automatic clear_search_state();
    int i;
    for (i = 0; i < NEEDLE_SLOTS; i++) win_bytes[i] = '0;
    bytes_seen   = 0;
    hit_reported = 0;
  endtask

  // Advance the search by one accepted byte and queue any result it causes
  task automatic search_predict(input octet_t b, input logic last);
    logic [127:0]   pat;
    int             len;
    int             i;
    bit             hit;
    search_result_t r;
    pat = {pat_hi, pat_lo};
    len = (pat_len > NEEDLE_SLOTS) ? NEEDLE_SLOTS : pat_len;
    hit = 0;
    if (hit_reported) begin
      if (last) clear_search_state();
    end else begin
      if (bytes_seen >= HAY_LIMIT) begin
        bytes_seen = HAY_LIMIT + 1;
      end else begin
        for (i = NEEDLE_SLOTS - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
        win_bytes[0] = b;
        bytes_seen++;
        hit = (bytes_seen >= len);
        for (i = 0; hit && i < len; i++) begin
          if (caps(pat[i*8 +: 8]) != caps(win_bytes[len-1-i])) hit = 0;
        end
        if (hit) begin
          r.found  = 1'b1;
          r.offset = (len == 0) ? '0 : OFF_W'(bytes_seen - len);
          r.ovf    = 1'b0;
          pending_results.push_back(r);
          if (last) clear_search_state();
          else hit_reported = 1;
        end
      end
      if (!hit && last) begin
        r.found  = 1'b0;
        r.offset = '0;
        r.ovf    = (bytes_seen > HAY_LIMIT);
        pending_results.push_back(r);
        clear_search_state();
      end
    end
  endtask

  // Offer one beat, idling first at random, and predict once it is taken
  task automatic send_byte(input octet_t b, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
    search_predict(b, last);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Drop valid, wait for every result, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [4:0] len, input logic fold);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NEEDLE_LO;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_NEEDLE_HI;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= CFG_NEEDLE_LEN;
    cfg_wdata <= CFG_W'(len);
    @(posedge clk);
    cfg_index <= CFG_FOLD_CASE;
    cfg_wdata <= CFG_W'(fold);
    @(posedge clk);
    cfg_we  <= 1'b0;
    pat_lo  = lo;
    pat_hi  = hi;
    pat_len = len;
    fold_on = fold;
  endtask

  // Pick a needle mostly of a few letters in mixed case so matches occur
  task automatic random_config();
    logic [127:0] pat;
    int           i;
    int           r;
    logic [4:0]   len;
    for (i = 0; i < NEEDLE_SLOTS; i++) begin
      if ($urandom_range(3) == 0) pat[i*8 +: 8] = 8'($urandom_range(255));
      else pat[i*8 +: 8] = 8'(8'h61 + $urandom_range(2)) ^ ($urandom_range(1) ? 8'h20 : 8'h00);
    end
    r = $urandom_range(99);
    if (r < 10) len = '0;
    else if (r < 60) len = 5'($urandom_range(1, 4));
    else if (r < 85) len = 5'($urandom_range(5, 16));
    else len = 5'($urandom_range(17, 31));
    configure(pat[63:0], pat[127:64], len, 1'($urandom_range(1)));
  endtask

  // Build one haystack, often with the needle planted in it, and send it
  task automatic random_haystack();
    octet_t       hay [$];
    logic [127:0] pat;
    octet_t       b;
    int           len;
    int           n;
    int           i;
    int           r;
    int           pos;
    pat = {pat_hi, pat_lo};
    len = (pat_len > NEEDLE_SLOTS) ? NEEDLE_SLOTS : pat_len;
    n = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
    for (i = 0; i < n; i++) begin
      r = $urandom_range(9);
      if (r < 5) b = 8'(8'h61 + $urandom_range(2)) ^ ($urandom_range(1) ? 8'h20 : 8'h00);
      else if (r < 8 && len > 0) b = pat[$urandom_range(len - 1)*8 +: 8];
      else b = 8'($urandom_range(255));
      hay.push_back(b);
    end
    if ($urandom_range(9) < 6 && len > 0 && len <= n) begin
      pos = $urandom_range(n - len);
      for (i = 0; i < len; i++) begin
        b = pat[i*8 +: 8];
        if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(1)) b ^= 8'h20;
        hay[pos + i] = b;
      end
    end
    for (i = 0; i < hay.size(); i++) send_byte(hay[i], i == hay.size() - 1);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 34;
    recv_idle_pct = 70;
    // empty needle after reset: hit on the first byte, rest ignored
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    // folded match, then a trailing byte that only closes the haystack
    configure(text_word("aZ"), '0, 2, 1'b1);
    send_text("xAzq");
    wait_idle();
    // exact compare, match completing on the last byte
    configure(text_word("aZ"), '0, 2, 1'b0);
    send_text("AzaZ");
    wait_idle();
    // oversized length saturates, needle longer than haystack
    configure(text_word("@[`{"), '1, 31, 1'b1);
    send_text("@[`{");
    wait_idle();
    // characters next to the letter ranges are not folded
    configure(text_word("@[`{"), '0, 4, 1'b1);
    send_text("`{@[`{");
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int count);
    int goal;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = sent_bytes + count;
    wait_idle();
    random_config();
    while (sent_bytes < goal) begin
      if ($urandom_range(5) == 0) begin
        wait_idle();
        random_config();
      end
      random_haystack();
    end
  endtask

  // Hold the output off while short haystacks keep coming
  task automatic test_output_backpressure();
    int     i;
    int     n;
    int     k;
    octet_t b;
    wait_idle();
    configure(text_word("k"), '0, 1, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go <= ~hold_go;
    for (k = 0; k < 80; k++) begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(2))
          0: b = 8'h6B;
          1: b = 8'h4B;
          default: b = 8'h78;
        endcase
        send_byte(b, i == n - 1);
      end
    end
  endtask

  // Drive ready at random, or hold it low for a long stretch on request
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_SPAN;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_beat
    search_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result found=%b offset=%0d overflow=%b",
                 $time, found, match_offset, overflow);
      end else begin
        want = pending_results.pop_front();
        if (found !== want.found || match_offset !== want.offset ||
            overflow !== want.ovf) begin
          fault_count++;
          $display("%0t: expected found=%b offset=%0d overflow=%b, got %b %0d %b",
                   $time, want.found, want.offset, want.ovf,
                   found, match_offset, overflow);
        end
      end
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_NEEDLE_LO;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    data_byte      = '0;
    last_byte      = 1'b0;
    out_ready      = 1'b0;
    hold_go        = 1'b0;
    hold_seen      = 1'b0;
    hold_left      = 0;
    idle_cycles    = 0;
    fault_count    = 0;
    sent_bytes     = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    pat_lo         = '0;
    pat_hi         = '0;
    pat_len        = '0;
    fold_on        = 1'b1;
    clear_search_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_traffic(34, 70, 600);
    test_random_traffic(70, 34, 600);
    test_random_traffic(0, 0, 600);
    test_output_backpressure();

    wait_idle();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
